/* rtl/skvt_pkg.sv */
// Package for the sorted key/value table: payload structs, result codes,
// sequencer states and the memory entry layout. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

    localparam int KEY_W   = 29;
    localparam int VALUE_W = 16;
    localparam int POS_W   = 7;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] stored_value;
        t_status            status;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_ADDR,
        S_SRCH_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE
    } t_state;

endpackage

`default_nettype wire

/* rtl/skvt_cmp.sv */
// Shared key comparator used by every binary search step.
// Depends on skvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skvt_cmp (
    input  wire logic [skvt_pkg::KEY_W-1:0] i_key,
    input  wire logic [skvt_pkg::KEY_W-1:0] i_entry_key,
    output skvt_pkg::t_cmp                  o_res
);
    import skvt_pkg::*;

    always_comb begin
        o_res.lt = (i_key < i_entry_key);
        o_res.eq = (i_key == i_entry_key);
    end

endmodule

`default_nettype wire

/* rtl/skvt_mem.sv */
// Entry store of the table: one write port and one read port with
// registered read data. Depends on skvt_pkg for the entry layout.
`timescale 1ns / 1ps
`default_nettype none

module skvt_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [ADDR_W-1:0]     i_waddr,
    input  wire skvt_pkg::t_entry      i_wdata,
    input  wire logic                  i_re,
    input  wire logic [ADDR_W-1:0]     i_raddr,
    output skvt_pkg::t_entry           o_rdata
);
    import skvt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/sorted_key_value_table_core.sv */
// Top level of the sorted key/value table: sequencer, search registers and
// result register. Depends on skvt_pkg, skvt_cmp and skvt_mem.
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when start is high and busy is low. Every command gives
// exactly one result, shown on o_result for the single cycle in which o_done
// is high; the receiver must take it then, as it cannot hold it off. The
// binary search runs on one shared comparator against a single-port read of
// the entry memory; each probe issues a read and then compares the key.
// An insert that adds an entry also moves every entry above the insertion
// point up by one through the same memory, reading each entry and then
// writing it one place higher, and then places the new pair. busy stays
// high until the result is shown.
module sorted_key_value_table_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire skvt_pkg::t_in i_item,
    output logic               o_done,
    output skvt_pkg::t_out     o_result
);
    import skvt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [CNT_W-1:0]     r_lo, n_lo;
    logic [CNT_W-1:0]     r_hi, n_hi;
    logic [IDX_W-1:0]     r_mid, n_mid;
    logic [CNT_W-1:0]     r_pos, n_pos;
    logic                 r_found, n_found;
    logic [VALUE_W-1:0]   r_sval, n_sval;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_done, n_done;
    t_out                 r_result, n_result;

    logic                 accept;
    logic [CNT_W:0]       lo_hi_sum;
    logic [IDX_W-1:0]     mid_c;
    logic [IDX_W-1:0]     idx_dec;
    logic                 search_open;
    logic                 table_full;
    t_cmp                 cmp_res;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    t_entry               mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    t_entry               mem_rdata;

    skvt_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    skvt_cmp u_cmp (
        .i_key       (r_key),
        .i_entry_key (mem_rdata.key),
        .o_res       (cmp_res)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign lo_hi_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_c       = lo_hi_sum[IDX_W:1];
    assign idx_dec     = r_idx - IDX_W'(1);
    assign search_open = (r_lo < r_hi);
    assign table_full  = (r_count >= CNT_W'(CAPACITY));
    assign o_done      = r_done;
    assign o_result    = r_result;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SRCH_ADDR;
                end
            end
            S_SRCH_ADDR: begin
                n_state = search_open ? S_SRCH_CMP : S_DECIDE;
            end
            S_SRCH_CMP: begin
                n_state = cmp_res.eq ? S_DECIDE : S_SRCH_ADDR;
            end
            S_DECIDE: begin
                if (r_op == OP_LOOKUP || r_found || table_full) begin
                    n_state = S_IDLE;
                end else if (r_count == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                n_state = (CNT_W'(idx_dec) == r_pos) ? S_PLACE : S_SHIFT_RD;
            end
            S_PLACE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result.
    always_comb begin
        n_op      = r_op;
        n_key     = r_key;
        n_value   = r_value;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_pos     = r_pos;
        n_found   = r_found;
        n_sval    = r_sval;
        n_idx     = r_idx;
        n_count   = r_count;
        n_done    = 1'b0;
        n_result  = r_result;
        mem_re    = 1'b0;
        mem_raddr = r_mid;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_item.operation;
                    n_key   = i_item.key;
                    n_value = i_item.value;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_found = 1'b0;
                    n_sval  = '0;
                end
            end
            S_SRCH_ADDR: begin
                if (search_open) begin
                    mem_re    = 1'b1;
                    mem_raddr = mid_c;
                    n_mid     = mid_c;
                end else begin
                    n_pos = r_lo;
                end
            end
            S_SRCH_CMP: begin
                if (cmp_res.eq) begin
                    n_found = 1'b1;
                    n_pos   = CNT_W'(r_mid);
                    n_sval  = mem_rdata.value;
                end else if (cmp_res.lt) begin
                    n_hi = CNT_W'(r_mid);
                end else begin
                    n_lo = CNT_W'(r_mid) + CNT_W'(1);
                end
            end
            S_DECIDE: begin
                n_result.found        = r_found;
                n_result.position     = POS_W'(r_pos);
                n_result.stored_value = r_sval;
                if (r_op == OP_LOOKUP) begin
                    n_result.status = r_found ? ST_OK : ST_MISS;
                    n_done          = 1'b1;
                end else if (r_found) begin
                    n_result.status = ST_DUP;
                    n_done          = 1'b1;
                end else if (table_full) begin
                    n_result.status = ST_FULL;
                    n_done          = 1'b1;
                end else begin
                    // Not full, so the count fits an entry index here.
                    n_idx = r_count[IDX_W-1:0];
                end
            end
            S_SHIFT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = idx_dec;
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_idx     = idx_dec;
            end
            S_PLACE: begin
                mem_we                = 1'b1;
                mem_waddr             = r_pos[IDX_W-1:0];
                mem_wdata.key         = r_key;
                mem_wdata.value       = r_value;
                n_count               = r_count + CNT_W'(1);
                n_result.found        = 1'b0;
                n_result.position     = POS_W'(r_pos);
                n_result.stored_value = '0;
                n_result.status       = ST_OK;
                n_done                = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_value  <= n_value;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_sval   <= n_sval;
        r_idx    <= n_idx;
        r_result <= n_result;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_done)
        else $error("result strobe right after a transaction was accepted");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(busy))
        else $error("result strobe without a command in progress");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("table full reported while entries remain free");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for sorted_key_value_table_core: directed table, then random traffic.
// Expected results come from a shadow copy of the sorted table kept in this file.
// Depends on skvt_pkg and the RTL of the core.
`timescale 1ns / 1ps

module testbench;
    import skvt_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int ITEMS_PER_PHASE = 463;
    localparam int TAIL_CYCLES     = 200;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam t_out NO_RES = '0;
    localparam int IDLE_PLAN [4] = '{0, 56, 0, 11};

    typedef struct packed {
        t_in  cmd;
        logic typed;
        t_out res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_done;
    t_out o_result;

    // Shadow of the table contents as the core should hold them.
    logic [KEY_W-1:0]   shadow_keys [CAPACITY];
    logic [VALUE_W-1:0] shadow_vals [CAPACITY];
    int                 shadow_count = 0;

    t_out expected_q [$];
    t_out want;
    int   error_count = 0;
    int   cycle_count = 0;
    int   idle_pct = 0;

    // Rows with a typed result are the ones that can be read off directly;
    // the others are checked against the shadow table.
    t_row directed_rows [20] = '{
        '{'{OP_LOOKUP, 29'h0000_0000, 16'h0000}, 1'b1, '{1'b0, 7'd0, 16'h0000, ST_MISS}},
        '{'{OP_LOOKUP, 29'h1FFF_FFFF, 16'hFFFF}, 1'b1, '{1'b0, 7'd0, 16'h0000, ST_MISS}},
        '{'{OP_INSERT, 29'h1FFF_FFFE, 16'hFFFF}, 1'b1, '{1'b0, 7'd0, 16'h0000, ST_OK}},
        '{'{OP_INSERT, 29'h0000_0000, 16'h0000}, 1'b1, '{1'b0, 7'd0, 16'h0000, ST_OK}},
        '{'{OP_LOOKUP, 29'h1FFF_FFFE, 16'h0000}, 1'b1, '{1'b1, 7'd1, 16'hFFFF, ST_OK}},
        '{'{OP_LOOKUP, 29'h0000_0000, 16'hFFFF}, 1'b1, '{1'b1, 7'd0, 16'h0000, ST_OK}},
        '{'{OP_INSERT, 29'h1FFF_FFFE, 16'h1234}, 1'b1, '{1'b1, 7'd1, 16'hFFFF, ST_DUP}},
        '{'{OP_LOOKUP, 29'h1FFF_FFFF, 16'h1234}, 1'b1, '{1'b0, 7'd2, 16'h0000, ST_MISS}},
        '{'{OP_INSERT, 29'h1000_0000, 16'hAAAA}, 1'b1, '{1'b0, 7'd1, 16'h0000, ST_OK}},
        '{'{OP_INSERT, 29'h0AAA_AAAA, 16'h5555}, 1'b1, '{1'b0, 7'd1, 16'h0000, ST_OK}},
        '{'{OP_INSERT, 29'h1555_5555, 16'h0001}, 1'b1, '{1'b0, 7'd3, 16'h0000, ST_OK}},
        '{'{OP_INSERT, 29'h0000_0001, 16'h8000}, 1'b0, NO_RES},
        '{'{OP_LOOKUP, 29'h1000_0000, 16'h0000}, 1'b0, NO_RES},
        '{'{OP_LOOKUP, 29'h0FFF_FFFF, 16'h0000}, 1'b0, NO_RES},
        '{'{OP_LOOKUP, 29'h1000_0001, 16'hFFFF}, 1'b0, NO_RES},
        '{'{OP_INSERT, 29'h0000_0000, 16'hFFFF}, 1'b0, NO_RES},
        '{'{OP_LOOKUP, 29'h0000_0001, 16'h0000}, 1'b0, NO_RES},
        '{'{OP_INSERT, 29'h1555_5554, 16'h7FFF}, 1'b0, NO_RES},
        '{'{OP_LOOKUP, 29'h1555_5555, 16'hFFFF}, 1'b0, NO_RES},
        '{'{OP_LOOKUP, 29'h1FFF_FFFF, 16'h0000}, 1'b0, NO_RES}
    };

    sorted_key_value_table_core #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Binary search on the shadow table, then the insert if one is due.
    function automatic t_out table_apply(input t_in cmd);
        int   lo;
        int   hi;
        int   mid;
        int   slot;
        bit   hit;
        t_out res;
        lo  = 0;
        hi  = shadow_count;
        mid = 0;
        hit = 1'b0;
        while (lo < hi && !hit) begin
            mid = (lo + hi) / 2;
            if (cmd.key < shadow_keys[mid]) begin
                hi = mid;
            end else if (cmd.key > shadow_keys[mid]) begin
                lo = mid + 1;
            end else begin
                hit = 1'b1;
            end
        end
        slot = hit ? mid : lo;
        res.found        = hit;
        res.position     = slot[POS_W-1:0];
        res.stored_value = hit ? shadow_vals[slot] : '0;
        if (cmd.operation == OP_LOOKUP) begin
            res.status = hit ? ST_OK : ST_MISS;
        end else if (hit) begin
            res.status = ST_DUP;
        end else if (shadow_count >= CAPACITY) begin
            res.status = ST_FULL;
        end else begin
            for (int i = shadow_count; i > slot; i--) begin
                shadow_keys[i] = shadow_keys[i-1];
                shadow_vals[i] = shadow_vals[i-1];
            end
            shadow_keys[slot] = cmd.key;
            shadow_vals[slot] = cmd.value;
            shadow_count++;
            res.status = ST_OK;
        end
        return res;
    endfunction

    // Mostly lookups of keys that are present or just beside them; inserts are
    // kept rare so that the table fills up over several idle phases.
    function automatic t_in pick_command();
        t_in              cmd;
        int               roll;
        int               hit_cut;
        int               near_cut;
        int               rand_cut;
        logic [31:0]      bits;
        logic [KEY_W-1:0] near;
        bits          = $urandom();
        cmd.value     = bits[VALUE_W-1:0];
        cmd.operation = ($urandom_range(0, 9) == 0) ? OP_INSERT : OP_LOOKUP;
        bits          = $urandom();
        near          = bits[KEY_W-1:0];
        if (shadow_count > 0) begin
            near = shadow_keys[$urandom_range(0, shadow_count - 1)];
        end
        if (cmd.operation == OP_LOOKUP) begin
            hit_cut  = 50;
            near_cut = 70;
            rand_cut = 85;
        end else begin
            hit_cut  = 35;
            near_cut = 50;
            rand_cut = 90;
        end
        roll = $urandom_range(0, 99);
        bits = $urandom();
        if (roll < hit_cut) begin
            cmd.key = near;
        end else if (roll < near_cut) begin
            cmd.key = bits[0] ? near + 1'b1 : near - 1'b1;
        end else if (roll < rand_cut) begin
            cmd.key = bits[KEY_W-1:0];
        end else begin
            case (bits[1:0])
                2'd0:    cmd.key = '0;
                2'd1:    cmd.key = 29'd1;
                2'd2:    cmd.key = KEY_MAX - 1'b1;
                default: cmd.key = KEY_MAX;
            endcase
        end
        // The top key stays out of the table, so that once it is full a search
        // for it lands past the last entry.
        if (cmd.operation == OP_INSERT && cmd.key == KEY_MAX && shadow_count < CAPACITY) begin
            cmd.key = KEY_MAX - 1'b1;
        end
        return cmd;
    endfunction

    task automatic issue(input t_in cmd, input bit typed, input t_out typed_res);
        t_out predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = table_apply(cmd);
        expected_q.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result with no transaction outstanding, got %h", $time, o_result);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("found", 16'(want.found), 16'(o_result.found));
                check_field("position", 16'(want.position), 16'(o_result.position));
                check_field("stored_value", want.stored_value, o_result.stored_value);
                check_field("status", 16'(want.status), 16'(o_result.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
        end
        drain();

        // Each phase ends with the sender holding off until all results are in.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = IDLE_PLAN[phase];
            repeat (ITEMS_PER_PHASE) issue(pick_command(), 1'b0, NO_RES);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
